// File: rtl/psr_pkg.sv
// Shared constants, types and helper functions for the polar-to-Cartesian resampler.
package psr_pkg;

  // Fixed field widths
  localparam int OP_W       = 1;
  localparam int SRAD_W     = 7;
  localparam int SANG_W     = 8;
  localparam int VAL_W      = 16;
  localparam int PIX_W      = 11;
  localparam int MR_W       = 8;
  localparam int ZF_W       = 4;
  localparam int ST_W       = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  // Default sizing
  localparam int DEF_MAX_RADIUS      = 128;
  localparam int DEF_MAX_ANGLE_STEPS = 256;
  localparam int DEF_MAX_ZOOM        = 8;

  // Register reset values
  localparam logic [MR_W-1:0] RST_MAX_RADIUS  = 8'd128;
  localparam logic [ZF_W-1:0] RST_ZOOM_FACTOR = 4'd1;
  localparam logic [ST_W-1:0] RST_ANGLE_STEPS = 9'd256;

  // Fixed point
  localparam int FRAC_W        = 8;            // radius and angle fraction bits
  localparam int RAD_SHIFT     = 2 * FRAC_W;   // pre-shift of the squared radius
  localparam int ANG_W         = 24;           // binary angle, one turn = 2^24
  localparam int ANG_SHIFT     = ANG_W - FRAC_W;
  localparam int CORDIC_STAGES = 20;
  localparam int CORDIC_GUARD  = 16;           // vector pre-scale, as shift
  localparam int ROUND_BIAS    = 32768;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RADIUS  = 2'd0,
    CFG_ZOOM_FACTOR = 2'd1,
    CFG_ANGLE_STEPS = 2'd2
  } cfg_reg_t;

  // Control and write payload that travels alongside the arithmetic
  typedef struct packed {
    logic                     valid;
    logic                     op;
    logic                     in_disc;
    logic [SRAD_W-1:0]        radius;
    logic [SANG_W-1:0]        angle;
    logic signed [VAL_W-1:0]  value;
  } psr_meta_t;

  // Width of the centered coordinates X and Y (signed)
  function automatic int coord_w(int max_radius, int max_zoom);
    int mw;
    mw = $clog2(max_radius * max_zoom + 1);
    return ((mw > PIX_W) ? mw : PIX_W) + 1;
  endfunction

  // Sum of the root digits and quotient bits of the radius path, squared radius to Q8 radius
  function automatic int radius_lat(int max_radius, int max_zoom);
    return coord_w(max_radius, max_zoom) + FRAC_W + $clog2(max_radius) + FRAC_W;
  endfunction

  // Reduce a narrow index below a constant modulus
  function automatic int wrap_index(int value, int modulus);
    int v;
    v = value;
    for (int k = 7; k >= 0; k--) begin
      if (v >= (modulus << k)) v = v - (modulus << k);
    end
    return v;
  endfunction

  // round(atan(2^-i) / turn * 2^24)
  function automatic logic [ANG_W-1:0] cordic_atan(int i);
    logic [ANG_W-1:0] a;
    case (i)
      0:       a = 24'd2097152;
      1:       a = 24'd1238021;
      2:       a = 24'd654136;
      3:       a = 24'd332050;
      4:       a = 24'd166669;
      5:       a = 24'd83416;
      6:       a = 24'd41718;
      7:       a = 24'd20860;
      8:       a = 24'd10430;
      9:       a = 24'd5215;
      10:      a = 24'd2608;
      11:      a = 24'd1304;
      12:      a = 24'd652;
      13:      a = 24'd326;
      14:      a = 24'd163;
      15:      a = 24'd81;
      16:      a = 24'd41;
      17:      a = 24'd20;
      18:      a = 24'd10;
      19:      a = 24'd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/psr_in_if.sv
// Request channel: sample writes and pixel queries.
interface psr_in_if;
  logic                                valid;
  logic                                ready;
  logic [psr_pkg::OP_W-1:0]            op;
  logic [psr_pkg::SRAD_W-1:0]          sample_radius;
  logic [psr_pkg::SANG_W-1:0]          sample_angle;
  logic signed [psr_pkg::VAL_W-1:0]    sample_value;
  logic [psr_pkg::PIX_W-1:0]           pixel_column;
  logic [psr_pkg::PIX_W-1:0]           pixel_row;

  modport source (output valid, op, sample_radius, sample_angle, sample_value,
                  pixel_column, pixel_row, input ready);
  modport sink   (input valid, op, sample_radius, sample_angle, sample_value,
                  pixel_column, pixel_row, output ready);
endinterface

// File: rtl/psr_out_if.sv
// Response channel: interpolated pixels.
interface psr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [psr_pkg::VAL_W-1:0]  pixel_value;
  logic                              inside_res;

  modport source (output valid, pixel_value, inside_res, input ready);
  modport sink   (input valid, pixel_value, inside_res, output ready);
endinterface

// File: rtl/psr_front.sv
// Front end: register clamping, centered coordinates, squared radius and limit.
module psr_front #(
  parameter int MAX_RADIUS      = psr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ANGLE_STEPS = psr_pkg::DEF_MAX_ANGLE_STEPS,
  parameter int MAX_ZOOM        = psr_pkg::DEF_MAX_ZOOM,
  localparam int MRW = $clog2(MAX_RADIUS + 1),
  localparam int ZW  = $clog2(MAX_ZOOM + 1),
  localparam int STW = $clog2(MAX_ANGLE_STEPS + 1),
  localparam int MW  = $clog2(MAX_RADIUS * MAX_ZOOM + 1),
  localparam int CW  = psr_pkg::coord_w(MAX_RADIUS, MAX_ZOOM),
  localparam int SW  = 2 * CW
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  psr_pkg::psr_meta_t             meta_in,
  input  logic [psr_pkg::PIX_W-1:0]      pixel_column,
  input  logic [psr_pkg::PIX_W-1:0]      pixel_row,
  input  logic [psr_pkg::MR_W-1:0]       max_radius,
  input  logic [psr_pkg::ZF_W-1:0]       zoom_factor,
  input  logic [psr_pkg::ST_W-1:0]       angle_steps,
  output psr_pkg::psr_meta_t             meta,
  output logic [SW-1:0]                  sum_sq,
  output logic [SW-1:0]                  lim_sq,
  output logic signed [CW-1:0]           x_pos,
  output logic signed [CW-1:0]           y_pos,
  output logic                           mr_ok,
  output logic [ZW-1:0]                  zf,
  output logic [STW-1:0]                 st
);

  logic [MRW-1:0]        mr_c;
  logic [ZW-1:0]         zf_c;
  logic [STW-1:0]        st_c;
  logic [MRW+ZW-1:0]     m_prod;
  logic [MRW+ZW-1:0]     lim_prod;
  logic [MW-1:0]         m_c;
  logic signed [CW-1:0]  x_c;
  logic signed [CW-1:0]  y_c;

  psr_pkg::psr_meta_t    meta1;
  logic signed [CW-1:0]  x1;
  logic signed [CW-1:0]  y1;
  logic [MW-1:0]         lim1;
  logic                  mr_ok1;
  logic [ZW-1:0]         zf1;
  logic [STW-1:0]        st1;

  logic signed [SW-1:0]  sq_x;
  logic signed [SW-1:0]  sq_y;
  logic [SW-1:0]         lim_sq_c;

  // Saturate the registers to the built sizes; a zero zoom or step count becomes one
  always_comb begin
    if (32'(max_radius) > MAX_RADIUS) mr_c = MRW'(MAX_RADIUS);
    else mr_c = MRW'(max_radius);
    if (zoom_factor == '0) zf_c = ZW'(1);
    else if (32'(zoom_factor) > MAX_ZOOM) zf_c = ZW'(MAX_ZOOM);
    else zf_c = ZW'(zoom_factor);
    if (angle_steps == '0) st_c = STW'(1);
    else if (32'(angle_steps) > MAX_ANGLE_STEPS) st_c = STW'(MAX_ANGLE_STEPS);
    else st_c = STW'(angle_steps);
  end

  assign m_prod   = mr_c * zf_c;
  assign lim_prod = (mr_c - MRW'(1)) * zf_c;
  assign m_c      = MW'(m_prod);
  assign x_c = $signed({{(CW-psr_pkg::PIX_W){1'b0}}, pixel_column})
             - $signed({{(CW-MW){1'b0}}, m_c});
  assign y_c = $signed({{(CW-MW){1'b0}}, m_c})
             - $signed({{(CW-psr_pkg::PIX_W){1'b0}}, pixel_row});

  assign sq_x     = x1 * x1;
  assign sq_y     = y1 * y1;
  assign lim_sq_c = lim1 * lim1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
      meta.valid  <= 1'b0;
    end else if (adv) begin
      meta1  <= meta_in;
      x1     <= x_c;
      y1     <= y_c;
      mr_ok1 <= (mr_c >= MRW'(2));
      lim1   <= (mr_c >= MRW'(2)) ? MW'(lim_prod) : '0;
      zf1    <= zf_c;
      st1    <= st_c;

      meta   <= meta1;
      sum_sq <= SW'(sq_x) + SW'(sq_y);
      lim_sq <= lim_sq_c;
      x_pos  <= x1;
      y_pos  <= y1;
      mr_ok  <= mr_ok1;
      zf     <= zf1;
      st     <= st1;
    end
  end

endmodule

// File: rtl/psr_radius.sv
// Radius path: pipelined square root, then pipelined division by the zoom.
module psr_radius #(
  parameter int MAX_RADIUS = psr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ZOOM   = psr_pkg::DEF_MAX_ZOOM,
  localparam int CW  = psr_pkg::coord_w(MAX_RADIUS, MAX_ZOOM),
  localparam int SW  = 2 * CW,
  localparam int NW  = SW + psr_pkg::RAD_SHIFT,
  localparam int QW  = NW / 2,
  localparam int ZW  = $clog2(MAX_ZOOM + 1),
  localparam int RQW = $clog2(MAX_RADIUS) + psr_pkg::FRAC_W
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [SW-1:0]   sum_sq,
  input  logic [ZW-1:0]   zf,
  output logic [RQW-1:0]  rq8
);

  // Square root, one result bit per stage
  logic [NW-1:0] rad    [QW-1];
  logic [QW+1:0] rem    [QW];
  logic [QW-1:0] root   [QW];
  logic [ZW-1:0] zf_sq  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    logic [NW-1:0] rad_in;
    logic [QW+1:0] rem_in;
    logic [QW-1:0] root_in;
    logic [ZW-1:0] zf_in;
    logic [QW+3:0] trial_rem;
    logic [QW+3:0] trial;

    if (k == 0) begin : g_first
      assign rad_in  = {sum_sq, {psr_pkg::RAD_SHIFT{1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
      assign zf_in   = zf;
    end else begin : g_next
      assign rad_in  = rad[k-1];
      assign rem_in  = rem[k-1];
      assign root_in = root[k-1];
      assign zf_in   = zf_sq[k-1];
    end

    assign trial_rem = {rem_in, rad_in[NW-1 -: 2]};
    assign trial     = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (trial_rem >= trial) begin
          rem[k]  <= (QW+2)'(trial_rem - trial);
          root[k] <= {root_in[QW-2:0], 1'b1};
        end else begin
          rem[k]  <= (QW+2)'(trial_rem);
          root[k] <= {root_in[QW-2:0], 1'b0};
        end
        zf_sq[k] <= zf_in;
      end
    end

    if (k < QW - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (adv) rad[k] <= rad_in << 2;
      end
    end
  end

  // Restoring division; only the low RQW quotient bits can be nonzero inside the disc
  logic [QW-1:0]  num   [RQW-1];
  logic [ZW-1:0]  drem  [RQW];
  logic [RQW-1:0] quo   [RQW];
  logic [ZW-1:0]  zf_dv [RQW-1];

  for (genvar j = 0; j < RQW; j++) begin : g_div
    logic [QW-1:0]  num_in;
    logic [ZW-1:0]  rem_in;
    logic [RQW-1:0] quo_in;
    logic [ZW-1:0]  zf_in;
    logic [ZW:0]    part;

    if (j == 0) begin : g_first
      assign num_in = root[QW-1];
      assign rem_in = ZW'(root[QW-1] >> RQW);
      assign quo_in = '0;
      assign zf_in  = zf_sq[QW-1];
    end else begin : g_next
      assign num_in = num[j-1];
      assign rem_in = drem[j-1];
      assign quo_in = quo[j-1];
      assign zf_in  = zf_dv[j-1];
    end

    assign part = {rem_in, num_in[RQW-1-j]};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (part >= {1'b0, zf_in}) begin
          drem[j] <= ZW'(part - {1'b0, zf_in});
          quo[j]  <= {quo_in[RQW-2:0], 1'b1};
        end else begin
          drem[j] <= ZW'(part);
          quo[j]  <= {quo_in[RQW-2:0], 1'b0};
        end
      end
    end

    if (j < RQW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          num[j]   <= num_in;
          zf_dv[j] <= zf_in;
        end
      end
    end
  end

  assign rq8 = quo[RQW-1];

endmodule

// File: rtl/psr_angle.sv
// Angle path: CORDIC vectoring, scaling to angle steps and neighbor index.
module psr_angle #(
  parameter int MAX_RADIUS      = psr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ANGLE_STEPS = psr_pkg::DEF_MAX_ANGLE_STEPS,
  parameter int MAX_ZOOM        = psr_pkg::DEF_MAX_ZOOM,
  parameter int LAT             = psr_pkg::radius_lat(psr_pkg::DEF_MAX_RADIUS,
                                                      psr_pkg::DEF_MAX_ZOOM),
  localparam int CW   = psr_pkg::coord_w(MAX_RADIUS, MAX_ZOOM),
  localparam int XW   = CW + psr_pkg::CORDIC_GUARD + 2,
  localparam int STW  = $clog2(MAX_ANGLE_STEPS + 1),
  localparam int ANGW = $clog2(MAX_ANGLE_STEPS),
  localparam int FQW  = ANGW + psr_pkg::FRAC_W,
  localparam int CS   = psr_pkg::CORDIC_STAGES,
  localparam int PAD  = LAT - (CS + 3)
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic signed [CW-1:0]            x_pos,
  input  logic signed [CW-1:0]            y_pos,
  input  logic [STW-1:0]                  st,
  output logic [ANGW-1:0]                 fmin,
  output logic [ANGW-1:0]                 fmax,
  output logic [psr_pkg::FRAC_W-1:0]      fo
);

  logic signed [XW-1:0]         xs   [CS+1];
  logic signed [XW-1:0]         ys   [CS+1];
  logic [psr_pkg::ANG_W-1:0]    zs   [CS+1];
  logic                         zero [CS+1];
  logic [STW-1:0]               st_a [CS+1];

  logic signed [XW-1:0]         x_ext;
  logic signed [XW-1:0]         y_ext;
  logic                         neg;

  // Fold the left half plane onto the right, starting half a turn away
  assign x_ext = XW'(x_pos);
  assign y_ext = XW'(y_pos);
  assign neg   = x_pos[CW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      xs[0]   <= (neg ? -x_ext : x_ext) <<< psr_pkg::CORDIC_GUARD;
      ys[0]   <= (neg ? -y_ext : y_ext) <<< psr_pkg::CORDIC_GUARD;
      zs[0]   <= neg ? {1'b1, {(psr_pkg::ANG_W-1){1'b0}}} : '0;
      zero[0] <= (x_pos == '0) && (y_pos == '0);
      st_a[0] <= st;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 up;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign up = !ys[i][XW-1] && (ys[i] != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (up) begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + psr_pkg::cordic_atan(i);
        end else begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - psr_pkg::cordic_atan(i);
        end
        zero[i+1] <= zero[i];
        st_a[i+1] <= st_a[i];
      end
    end
  end

  logic [psr_pkg::ANG_W-1:0]     z_fin;
  logic [psr_pkg::ANG_W+STW-1:0] zprod;
  logic [FQW-1:0]                fq8;
  logic [STW-1:0]                st_m;
  logic [ANGW:0]                 inc;
  logic [ANGW-1:0]               fmin_r;
  logic [ANGW-1:0]               fmax_r;
  logic [psr_pkg::FRAC_W-1:0]    fo_r;

  assign z_fin = zero[CS] ? '0 : zs[CS];
  assign zprod = z_fin * st_a[CS];
  assign inc   = {1'b0, fq8[FQW-1:psr_pkg::FRAC_W]} + (ANGW+1)'(1);

  always_ff @(posedge clk) begin
    if (adv) begin
      fq8    <= zprod[psr_pkg::ANG_SHIFT +: FQW];
      st_m   <= st_a[CS];
      fmin_r <= fq8[FQW-1:psr_pkg::FRAC_W];
      fo_r   <= fq8[psr_pkg::FRAC_W-1:0];
      // Wrap the upper angle neighbor at the step count
      fmax_r <= (inc >= (ANGW+1)'(st_m)) ? '0 : inc[ANGW-1:0];
    end
  end

  if (PAD > 0) begin : g_pad
    logic [ANGW-1:0]            fmin_d [PAD];
    logic [ANGW-1:0]            fmax_d [PAD];
    logic [psr_pkg::FRAC_W-1:0] fo_d   [PAD];

    always_ff @(posedge clk) begin
      if (adv) begin
        fmin_d[0] <= fmin_r;
        fmax_d[0] <= fmax_r;
        fo_d[0]   <= fo_r;
        for (int p = 1; p < PAD; p++) begin
          fmin_d[p] <= fmin_d[p-1];
          fmax_d[p] <= fmax_d[p-1];
          fo_d[p]   <= fo_d[p-1];
        end
      end
    end

    assign fmin = fmin_d[PAD-1];
    assign fmax = fmax_d[PAD-1];
    assign fo   = fo_d[PAD-1];
  end else begin : g_nopad
    assign fmin = fmin_r;
    assign fmax = fmax_r;
    assign fo   = fo_r;
  end

endmodule

// File: rtl/psr_samples.sv
// Polar sample store (four read copies) and the bilinear blend.
module psr_samples #(
  parameter int MAX_RADIUS      = psr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ANGLE_STEPS = psr_pkg::DEF_MAX_ANGLE_STEPS,
  localparam int DEPTH = MAX_RADIUS * MAX_ANGLE_STEPS,
  localparam int AW    = $clog2(DEPTH),
  localparam int RADW  = $clog2(MAX_RADIUS),
  localparam int ANGW  = $clog2(MAX_ANGLE_STEPS),
  localparam int RQW   = RADW + psr_pkg::FRAC_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  psr_pkg::psr_meta_t                meta_in,
  input  logic [RQW-1:0]                    rq8,
  input  logic [ANGW-1:0]                   fmin,
  input  logic [ANGW-1:0]                   fmax,
  input  logic [psr_pkg::FRAC_W-1:0]        fo,
  output logic                              out_valid,
  output logic signed [psr_pkg::VAL_W-1:0]  pixel_value,
  output logic                              inside_res
);

  localparam int WW = 2 * psr_pkg::FRAC_W + 1;
  localparam int PW = psr_pkg::VAL_W + WW + 1;
  localparam int AccW = PW + 2;
  localparam logic [psr_pkg::FRAC_W:0] ONE =
    (psr_pkg::FRAC_W + 1)'(1 << psr_pkg::FRAC_W);

  logic [RADW-1:0]              rmin;
  logic [RADW-1:0]              rmax;
  logic [psr_pkg::FRAC_W-1:0]   ro;
  logic [AW-1:0]                addr [4];
  logic [RADW-1:0]              wr_r;
  logic [ANGW-1:0]              wr_a;
  logic [AW-1:0]                wr_addr;
  logic                         wr_en;
  logic [psr_pkg::FRAC_W:0]     ro_c;
  logic [psr_pkg::FRAC_W:0]     fo_c;
  logic [WW-1:0]                w_c  [4];

  assign rmin = rq8[RQW-1:psr_pkg::FRAC_W];
  assign rmax = rmin + RADW'(1);
  assign ro   = rq8[psr_pkg::FRAC_W-1:0];

  assign addr[0] = AW'(rmin) * AW'(MAX_ANGLE_STEPS) + AW'(fmin);
  assign addr[1] = AW'(rmax) * AW'(MAX_ANGLE_STEPS) + AW'(fmin);
  assign addr[2] = AW'(rmin) * AW'(MAX_ANGLE_STEPS) + AW'(fmax);
  assign addr[3] = AW'(rmax) * AW'(MAX_ANGLE_STEPS) + AW'(fmax);

  assign wr_r    = RADW'(psr_pkg::wrap_index(int'(meta_in.radius), MAX_RADIUS));
  assign wr_a    = ANGW'(psr_pkg::wrap_index(int'(meta_in.angle), MAX_ANGLE_STEPS));
  assign wr_addr = AW'(wr_r) * AW'(MAX_ANGLE_STEPS) + AW'(wr_a);
  assign wr_en   = adv && meta_in.valid && (meta_in.op == psr_pkg::OP_WRITE);

  assign ro_c   = {1'b0, ro};
  assign fo_c   = {1'b0, fo};
  assign w_c[0] = (ONE - ro_c) * (ONE - fo_c);
  assign w_c[1] = ro_c * (ONE - fo_c);
  assign w_c[2] = (ONE - ro_c) * fo_c;
  assign w_c[3] = ro_c * fo_c;

  logic signed [psr_pkg::VAL_W-1:0] rd    [4];
  logic [WW-1:0]                    w1    [4];
  logic signed [PW-1:0]             prod  [4];
  psr_pkg::psr_meta_t               meta1;
  psr_pkg::psr_meta_t               meta2;

  // Every write lands in all copies; each copy serves one neighbor
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic signed [psr_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en) mem[wr_addr] <= meta_in.value;
      if (adv) begin
        rd[b]   <= mem[addr[b]];
        w1[b]   <= w_c[b];
        prod[b] <= rd[b] * $signed({1'b0, w1[b]});
      end
    end
  end

  logic signed [AccW-1:0] acc;

  assign acc = AccW'(prod[0]) + AccW'(prod[1]) + AccW'(prod[2]) + AccW'(prod[3])
             + AccW'(psr_pkg::ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
      meta2.valid <= 1'b0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      meta1       <= meta_in;
      meta2       <= meta1;
      out_valid   <= meta2.valid && (meta2.op == psr_pkg::OP_QUERY);
      inside_res  <= meta2.in_disc;
      pixel_value <= meta2.in_disc ? acc[2*psr_pkg::FRAC_W +: psr_pkg::VAL_W] : '0;
    end
  end

endmodule

// File: rtl/polar_to_cartesian_resampler.sv
// Top level: polar-to-Cartesian resampler with bilinear interpolation.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     op, sample_radius, sample_angle, sample_value,
//                                 pixel_column, pixel_row
//   rsp      out  valid/ready     pixel_value, inside_res
//   cfg      in   cfg_we          cfg_index, cfg_data
//
// One transaction per cycle while no result is held at rsp. The square-root and
// divider stages of the radius path set the pipeline depth.
// Reset loads the register reset values and clears all valid bits; sample memory is not cleared.
// A result held at rsp freezes the whole pipeline and drops req.ready.
module polar_to_cartesian_resampler #(
  parameter int MAX_RADIUS      = psr_pkg::DEF_MAX_RADIUS,
  parameter int MAX_ANGLE_STEPS = psr_pkg::DEF_MAX_ANGLE_STEPS,
  parameter int MAX_ZOOM        = psr_pkg::DEF_MAX_ZOOM
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]      cfg_data,
  psr_in_if.sink                              req,
  psr_out_if.source                           rsp
);

  localparam int CW   = psr_pkg::coord_w(MAX_RADIUS, MAX_ZOOM);
  localparam int SW   = 2 * CW;
  localparam int ZW   = $clog2(MAX_ZOOM + 1);
  localparam int STW  = $clog2(MAX_ANGLE_STEPS + 1);
  localparam int ANGW = $clog2(MAX_ANGLE_STEPS);
  localparam int RQW  = $clog2(MAX_RADIUS) + psr_pkg::FRAC_W;
  localparam int LR   = psr_pkg::radius_lat(MAX_RADIUS, MAX_ZOOM);

  logic [psr_pkg::MR_W-1:0] max_radius;
  logic [psr_pkg::ZF_W-1:0] zoom_factor;
  logic [psr_pkg::ST_W-1:0] angle_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius  <= psr_pkg::RST_MAX_RADIUS;
      zoom_factor <= psr_pkg::RST_ZOOM_FACTOR;
      angle_steps <= psr_pkg::RST_ANGLE_STEPS;
    end else if (cfg_we) begin
      case (psr_pkg::cfg_reg_t'(cfg_index))
        psr_pkg::CFG_MAX_RADIUS:  max_radius  <= cfg_data[psr_pkg::MR_W-1:0];
        psr_pkg::CFG_ZOOM_FACTOR: zoom_factor <= cfg_data[psr_pkg::ZF_W-1:0];
        psr_pkg::CFG_ANGLE_STEPS: angle_steps <= cfg_data[psr_pkg::ST_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid;

  // Advance everything unless a finished result is held
  assign adv       = !(out_valid && !rsp.ready);
  assign req.ready = adv;

  psr_pkg::psr_meta_t meta_in;

  always_comb begin
    meta_in.valid   = req.valid;
    meta_in.op      = req.op;
    meta_in.in_disc = 1'b0;
    meta_in.radius  = req.sample_radius;
    meta_in.angle   = req.sample_angle;
    meta_in.value   = req.sample_value;
  end

  psr_pkg::psr_meta_t    f_meta;
  logic [SW-1:0]         sum_sq;
  logic [SW-1:0]         lim_sq;
  logic signed [CW-1:0]  x_pos;
  logic signed [CW-1:0]  y_pos;
  logic                  mr_ok;
  logic [ZW-1:0]         zf;
  logic [STW-1:0]        st;

  psr_front #(
    .MAX_RADIUS      (MAX_RADIUS),
    .MAX_ANGLE_STEPS (MAX_ANGLE_STEPS),
    .MAX_ZOOM        (MAX_ZOOM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .meta_in      (meta_in),
    .pixel_column (req.pixel_column),
    .pixel_row    (req.pixel_row),
    .max_radius   (max_radius),
    .zoom_factor  (zoom_factor),
    .angle_steps  (angle_steps),
    .meta         (f_meta),
    .sum_sq       (sum_sq),
    .lim_sq       (lim_sq),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .mr_ok        (mr_ok),
    .zf           (zf),
    .st           (st)
  );

  logic [RQW-1:0] rq8;

  psr_radius #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_ZOOM   (MAX_ZOOM)
  ) u_radius (
    .clk    (clk),
    .adv    (adv),
    .sum_sq (sum_sq),
    .zf     (zf),
    .rq8    (rq8)
  );

  logic [ANGW-1:0]            fmin;
  logic [ANGW-1:0]            fmax;
  logic [psr_pkg::FRAC_W-1:0] fo;

  psr_angle #(
    .MAX_RADIUS      (MAX_RADIUS),
    .MAX_ANGLE_STEPS (MAX_ANGLE_STEPS),
    .MAX_ZOOM        (MAX_ZOOM),
    .LAT             (LR)
  ) u_angle (
    .clk   (clk),
    .adv   (adv),
    .x_pos (x_pos),
    .y_pos (y_pos),
    .st    (st),
    .fmin  (fmin),
    .fmax  (fmax),
    .fo    (fo)
  );

  // Tag the transaction with the disc test before it enters the control line
  psr_pkg::psr_meta_t f_meta_tag;

  always_comb begin
    f_meta_tag         = f_meta;
    f_meta_tag.in_disc = mr_ok && (sum_sq < lim_sq);
  end

  // Control line alongside the radius and angle paths
  psr_pkg::psr_meta_t meta_dl [LR];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LR; k++) meta_dl[k].valid <= 1'b0;
    end else if (adv) begin
      meta_dl[0] <= f_meta_tag;
      for (int k = 1; k < LR; k++) meta_dl[k] <= meta_dl[k-1];
    end
  end

  psr_samples #(
    .MAX_RADIUS      (MAX_RADIUS),
    .MAX_ANGLE_STEPS (MAX_ANGLE_STEPS)
  ) u_samples (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .meta_in     (meta_dl[LR-1]),
    .rq8         (rq8),
    .fmin        (fmin),
    .fmax        (fmax),
    .fo          (fo),
    .out_valid   (out_valid),
    .pixel_value (rsp.pixel_value),
    .inside_res  (rsp.inside_res)
  );

  assign rsp.valid = out_valid;

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.inside_res |-> rsp.pixel_value == '0)
    else $error("pixel outside the disc carries a nonzero value");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("request stalled without a held response");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    meta_dl[LR-1].valid && adv && meta_dl[LR-1].op == psr_pkg::OP_WRITE
      |-> ##3 !rsp.valid || !$past(adv, 1) || !$past(adv, 2))
    else $error("sample write produced a response");

endmodule

// File: bench/psr_checker.sv
// Checker: watches the request, response and register ports and checks every pixel result.
`timescale 1ns / 100ps
module psr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [psr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0]  cfg_data,
  psr_in_if                               req,
  psr_out_if                              rsp,
  output int                              errors,
  output int                              pending,
  output int                              inside_hits
);
  import psr_pkg::*;

  localparam int RADII = 128;
  localparam int ANGLES = 256;
  localparam int ZOOM_CAP = 8;

  localparam longint ATAN_TURN [0:19] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    in_disc;
  } pixel_t;

  pixel_t                  pixel_q[$];
  logic signed [VAL_W-1:0] polar_mem [0:RADII*ANGLES-1];
  logic [MR_W-1:0]         radius_reg;
  logic [ZF_W-1:0]         zoom_reg;
  logic [ST_W-1:0]         steps_reg;

  assign pending = pixel_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint xi, longint yi);
    longint xs, ys, z, dx, dy;
    if (xi == 0 && yi == 0) return 0;
    xs = xi;
    ys = yi;
    z = 0;
    if (xs < 0) begin
      xs = -xs;
      ys = -ys;
      z = 64'sd1 << 23;
    end
    xs = xs * 65536;
    ys = ys * 65536;
    for (int i = 0; i < 20; i++) begin
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys > 0) begin
        xs = xs + dx;
        ys = ys - dy;
        z = z + ATAN_TURN[i];
      end else begin
        xs = xs - dx;
        ys = ys + dy;
        z = z - ATAN_TURN[i];
      end
    end
    return z & 64'hFFFFFF;
  endfunction

  function automatic longint sample(longint r, longint a);
    return longint'(polar_mem[(r % RADII) * ANGLES + (a % ANGLES)]);
  endfunction

  function automatic pixel_t resample(longint col, longint row);
    pixel_t p;
    longint mr, zf, st, m, x, y, s, lim, rq8, rmin, ro, fq8, fmin, fmax, fo, acc;
    mr = (radius_reg > RADII) ? RADII : radius_reg;
    zf = (zoom_reg == 0) ? 1 : ((zoom_reg > ZOOM_CAP) ? ZOOM_CAP : zoom_reg);
    st = (steps_reg == 0) ? 1 : ((steps_reg > ANGLES) ? ANGLES : steps_reg);
    m = mr * zf;
    x = col - m;
    y = m - row;
    s = x * x + y * y;
    lim = (mr >= 2) ? (mr - 1) * zf : 0;
    p.value = '0;
    p.in_disc = 1'b0;
    if (mr < 2 || s >= lim * lim) return p;
    rq8 = longint'(int_sqrt(longint'(s) << 16)) / zf;
    rmin = rq8 >> 8;
    ro = rq8 & 255;
    fq8 = (vector_angle(x, y) * st) >> 16;
    fmin = fq8 >> 8;
    fo = fq8 & 255;
    fmax = (fmin + 1 >= st) ? 0 : fmin + 1;
    acc = sample(rmin, fmin) * ((256 - ro) * (256 - fo))
        + sample(rmin + 1, fmin) * (ro * (256 - fo))
        + sample(rmin, fmax) * ((256 - ro) * fo)
        + sample(rmin + 1, fmax) * (ro * fo);
    acc = (acc + 32768) >>> 16;
    p.value = acc[VAL_W-1:0];
    p.in_disc = 1'b1;
    return p;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    inside_hits = 0;
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      radius_reg <= RST_MAX_RADIUS;
      zoom_reg <= RST_ZOOM_FACTOR;
      steps_reg <= RST_ANGLE_STEPS;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_MAX_RADIUS:  radius_reg <= cfg_data[MR_W-1:0];
          CFG_ZOOM_FACTOR: zoom_reg <= cfg_data[ZF_W-1:0];
          CFG_ANGLE_STEPS: steps_reg <= cfg_data[ST_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.op == OP_WRITE) begin
          polar_mem[(req.sample_radius % RADII) * ANGLES + (req.sample_angle % ANGLES)] =
            req.sample_value;
        end else begin
          pixel_q.push_back(resample(req.pixel_column, req.pixel_row));
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected result", rsp.pixel_value, 0);
        end else begin
          want = pixel_q.pop_front();
          if (rsp.inside_res !== want.in_disc) report("inside_res", rsp.inside_res, want.in_disc);
          if (rsp.pixel_value !== want.value) report("pixel_value", rsp.pixel_value, want.value);
          if (want.in_disc) inside_hits++;
        end
      end
    end
  end
endmodule

// File: bench/tb_top.sv
// Testbench top: clock, reset, register phases, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import psr_pkg::*;

  // Polar region loaded up front; every setting used below reads only inside it
  localparam int LOAD_RADII  = 8;
  localparam int LOAD_ANGLES = 64;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending, inside_hits;
  int                    writes_sent, queries_sent;
  int                    eff_radius, eff_zoom;

  psr_in_if  req ();
  psr_out_if rsp ();

  polar_to_cartesian_resampler u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  psr_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .errors(errors), .pending(pending), .inside_hits(inside_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 100);
  endfunction

  // Response side: random ready runs, some long stalls, some long open stretches.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      rsp.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8))
        @(posedge clk);
      rsp.ready <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 4))
        @(posedge clk);
    end
  end

  task automatic send(logic op, logic [SRAD_W-1:0] rad, logic [SANG_W-1:0] ang,
                      logic signed [VAL_W-1:0] val, logic [PIX_W-1:0] col,
                      logic [PIX_W-1:0] row, int gap);
    logic got_ready;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.op <= op;
    req.sample_radius <= rad;
    req.sample_angle <= ang;
    req.sample_value <= val;
    req.pixel_column <= col;
    req.pixel_row <= row;
    do begin
      @(negedge clk);
      got_ready = req.ready;
      @(posedge clk);
    end while (!got_ready);
    if (op == OP_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  task automatic write_sample(int r, int a, int v, int gap);
    send(OP_WRITE, r[SRAD_W-1:0], a[SANG_W-1:0], v[VAL_W-1:0], PIX_W'($urandom),
         PIX_W'($urandom), gap);
  endtask

  task automatic query(int col, int row, int gap);
    send(OP_QUERY, SRAD_W'($urandom), SANG_W'($urandom), VAL_W'($urandom),
         col[PIX_W-1:0], row[PIX_W-1:0], gap);
  endtask

  // Hold the sender until every result is back, then let the pipeline empty.
  task automatic drain();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase(int mr, int zf, int st);
    drain();
    set_reg(CFG_MAX_RADIUS, mr);
    set_reg(CFG_ZOOM_FACTOR, zf);
    set_reg(CFG_ANGLE_STEPS, st);
    eff_radius = (mr[7:0] > 128) ? 128 : mr[7:0];
    eff_zoom = (zf[3:0] == 0) ? 1 : ((zf[3:0] > 8) ? 8 : zf[3:0]);
  endtask

  function automatic int clamp_pix(int v);
    return (v < 0) ? 0 : ((v > 2047) ? 2047 : v);
  endfunction

  task automatic random_mix(int count);
    int m, lim, pick;
    m = eff_radius * eff_zoom;
    lim = (eff_radius > 1) ? (eff_radius - 1) * eff_zoom : 1;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        write_sample($urandom_range(0, 127), $urandom_range(0, 255), $urandom, idle_len());
      end else if (pick < 30) begin
        query($urandom_range(0, 2047), $urandom_range(0, 2047), idle_len());
      end else begin
        query(clamp_pix(m + $urandom_range(0, 2 * lim + 4) - (lim + 2)),
              clamp_pix(m + $urandom_range(0, 2 * lim + 4) - (lim + 2)), idle_len());
      end
    end
  endtask

  initial begin
    writes_sent = 0;
    queries_sent = 0;
    eff_radius = 128;
    eff_zoom = 1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAX_RADIUS;
    cfg_data <= '0;
    req.valid <= 1'b0;
    req.op <= OP_WRITE;
    req.sample_radius <= '0;
    req.sample_angle <= '0;
    req.sample_value <= '0;
    req.pixel_column <= '0;
    req.pixel_row <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load the polar region that every later setting can reach.
    for (int r = 0; r < LOAD_RADII; r++) begin
      for (int a = 0; a < LOAD_ANGLES; a++) begin
        write_sample(r, a, $urandom, ($urandom_range(0, 49) == 0) ? idle_len() : 0);
      end
    end

    // Directed: extreme values, then pixels outside the disc at the reset setting.
    write_sample(0, 0, 32767, 0);
    write_sample(1, 0, -32768, 0);
    write_sample(0, 1, -32768, 1);
    write_sample(1, 1, 32767, 0);
    write_sample(127, 255, -1, 0);
    query(0, 0, 0);
    query(2047, 2047, 0);
    query(2047, 0, 0);
    query(0, 2047, 0);
    query(128 + 127, 128, 0);
    query(128, 1, 0);

    // Center, axes and the disc edge on a small disc.
    set_phase(8, 1, 64);
    query(8, 8, 0);
    query(9, 8, 0);
    query(8, 7, 0);
    query(7, 8, 2);
    query(8, 9, 0);
    query(8 + 6, 8, 0);
    query(8 + 7, 8, 0);
    query(8, 1, 0);
    query(8, 2, 0);
    query(1, 8, 0);
    query(7, 9, 0);
    query(12, 3, 0);
    random_mix(250);
    set_phase(2, 1, 1);
    query(2, 2, 0);
    query(3, 2, 0);
    random_mix(150);
    set_phase(8, 8, 64);
    query(64, 64, 0);
    query(64 + 55, 64, 0);
    query(64 + 56, 64, 0);
    query(2047, 2047, 0);
    random_mix(200);
    set_phase(5, 3, 7);
    random_mix(150);
    set_phase(7, 2, 50);
    random_mix(150);
    set_phase(8, 15, 0);
    random_mix(150);
    set_phase(0, 0, 0);
    random_mix(80);
    set_phase(1, 4, 2);
    random_mix(80);
    set_phase(6, 5, 63);
    random_mix(150);

    req.valid <= 1'b0;
    fork
      begin
        do @(negedge clk); while (pending != 0);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (60) @(posedge clk);
    $display("covered %0d sample writes and %0d pixel queries over ten register settings",
             writes_sent, queries_sent);
    $display("%0d results inside the disc, %0d mismatches, %0d results outstanding",
             inside_hits, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
